// ===== sv/avcc_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the avcc to annex-b nal converter
// no dependencies

package avcc_pkg;

  localparam int LENGTH_FIELD_BYTES = 4;
  localparam int SC_BEATS           = 4;
  localparam int QUEUE_DEPTH        = 8;

  typedef enum logic [1:0] {
    MODE_DISCARD = 2'd0,
    MODE_HEADER  = 2'd1,
    MODE_PAYLOAD = 2'd2
  } mode_t;

  typedef struct packed {
    logic       is_sc;
    logic [7:0] data;
    logic       nal_end;
  } group_t;

  typedef struct packed {
    logic   valid;
    group_t grp;
  } push_t;

endpackage

// ===== sv/avcc_in_if.sv =====
`timescale 1ns / 1ps
// sample byte channel: valid/ready handshake with the sample byte payload
// no dependencies

interface avcc_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  in_byte;
  logic        sample_first;
  logic [31:0] sample_len;

  modport source (output valid, output in_byte, output sample_first, output sample_len,
                  input ready);
  modport sink (input valid, input in_byte, input sample_first, input sample_len,
                output ready);
endinterface

// ===== sv/avcc_out_if.sv =====
`timescale 1ns / 1ps
// annex-b byte channel: valid/ready handshake with the emitted byte payload
// no dependencies

interface avcc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_start_code;
  logic       nal_end;
  logic       run_last;

  modport source (output valid, output out_byte, output is_start_code, output nal_end,
                  output run_last, input ready);
  modport sink (input valid, input out_byte, input is_start_code, input nal_end,
                input run_last, output ready);
endinterface

// ===== sv/avcc_to_annexb_nal_converter.sv =====
`timescale 1ns / 1ps
// avcc to annex-b converter: takes one sample byte per cycle while the queue is not full and
// gives one output beat per cycle when ready; results are queued and shown from the head
// a valid length header's fourth byte yields four start-code beats, a payload byte one beat
// a queue of QUEUE_DEPTH groups absorbs the start code; input stalls only when it is full
// reset empties the queue and sets the parser to discard until a first sample byte

module avcc_to_annexb_nal_converter #(
  parameter int QUEUE_DEPTH = avcc_pkg::QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  avcc_in_if.sink   samples,
  avcc_out_if.source nals
);

  avcc_pkg::mode_t mode;
  avcc_pkg::mode_t mode_next;
  logic [1:0]      header_count;
  logic [1:0]      header_count_next;
  logic [31:0]     length_accum;
  logic [31:0]     length_accum_next;
  logic [31:0]     nal_remaining;
  logic [31:0]     nal_remaining_next;
  logic [31:0]     sample_remaining;
  logic [31:0]     sample_remaining_next;

  avcc_pkg::push_t push;
  logic            full;
  logic            accept;

  avcc_pkg::mode_t cur_mode;
  logic [1:0]      cur_hc;
  logic [31:0]     cur_acc;
  logic [31:0]     cur_nr;
  logic [31:0]     cur_sr;
  logic [31:0]     acc_shift;
  logic [31:0]     nr_dec;

  assign samples.ready = !full;
  assign accept        = samples.valid && samples.ready;

  always_comb begin
    cur_mode = mode;
    cur_hc   = header_count;
    cur_acc  = length_accum;
    cur_nr   = nal_remaining;
    cur_sr   = sample_remaining;
    if (samples.sample_first) begin
      cur_mode = avcc_pkg::MODE_HEADER;
      cur_hc   = '0;
      cur_acc  = '0;
      cur_nr   = '0;
      cur_sr   = samples.sample_len;
    end
    acc_shift = {cur_acc[23:0], samples.in_byte};
    nr_dec    = (cur_nr != '0) ? cur_nr - 32'd1 : cur_nr;

    mode_next             = cur_mode;
    header_count_next     = cur_hc;
    length_accum_next     = cur_acc;
    nal_remaining_next    = cur_nr;
    sample_remaining_next = cur_sr;
    push                  = '0;

    if (cur_sr == '0) begin
      mode_next = avcc_pkg::MODE_DISCARD;
    end else begin
      sample_remaining_next = cur_sr - 32'd1;
      unique case (cur_mode)
        avcc_pkg::MODE_HEADER: begin
          length_accum_next = acc_shift;
          if (cur_hc == 2'(avcc_pkg::LENGTH_FIELD_BYTES - 1)) begin
            header_count_next = '0;
            // remaining after this byte is cur_sr - 1, so overlong is acc >= cur_sr
            if (acc_shift == '0 || acc_shift >= cur_sr) begin
              mode_next = avcc_pkg::MODE_DISCARD;
            end else begin
              mode_next          = avcc_pkg::MODE_PAYLOAD;
              nal_remaining_next = acc_shift;
              push.valid         = 1'b1;
              push.grp.is_sc     = 1'b1;
            end
          end else begin
            header_count_next = cur_hc + 2'd1;
          end
        end
        avcc_pkg::MODE_PAYLOAD: begin
          nal_remaining_next = nr_dec;
          push.valid         = 1'b1;
          push.grp.data      = samples.in_byte;
          push.grp.nal_end   = (nr_dec == '0);
          if (nr_dec == '0) begin
            mode_next         = avcc_pkg::MODE_HEADER;
            header_count_next = '0;
            length_accum_next = '0;
          end
        end
        default: begin
          mode_next = avcc_pkg::MODE_DISCARD;
        end
      endcase
    end
    push.valid = push.valid && accept;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode             <= avcc_pkg::MODE_DISCARD;
      header_count     <= '0;
      length_accum     <= '0;
      nal_remaining    <= '0;
      sample_remaining <= '0;
    end else if (accept) begin
      mode             <= mode_next;
      header_count     <= header_count_next;
      length_accum     <= length_accum_next;
      nal_remaining    <= nal_remaining_next;
      sample_remaining <= sample_remaining_next;
    end
  end

  avcc_emit #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_emit (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (full),
    .nals (nals)
  );

  a_reset_empty: assert property (@(posedge clk) rst |=> !nals.valid)
    else $error("output valid right after reset");

  a_payload_len: assert property (@(posedge clk) disable iff (rst)
    mode == avcc_pkg::MODE_PAYLOAD |-> nal_remaining != '0)
    else $error("payload mode with no bytes left in the nal");

  a_sc_contiguous: assert property (@(posedge clk) disable iff (rst)
    nals.valid && nals.ready && nals.is_start_code && !nals.run_last
      |=> nals.valid && nals.is_start_code)
    else $error("start code beats broken up");

  a_sc_last_byte: assert property (@(posedge clk) disable iff (rst)
    nals.valid && nals.is_start_code |-> (nals.run_last == (nals.out_byte == 8'h01)))
    else $error("start code byte does not match its beat position");

endmodule

// ===== sv/avcc_emit.sv =====
`timescale 1ns / 1ps
// result queue: holds parsed groups and expands a start code into four beats
// depends on avcc_pkg and avcc_out_if

module avcc_emit #(
  parameter int QUEUE_DEPTH = avcc_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  avcc_pkg::push_t   push,
  output logic              full,
  avcc_out_if.source        nals
);

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  avcc_pkg::group_t queue [QUEUE_DEPTH];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;
  logic [1:0]       sc_beat;

  avcc_pkg::group_t head;
  logic             sc_last;
  logic             beat;
  logic             pop;

  assign head    = queue[rd_ptr];
  assign sc_last = (sc_beat == 2'(avcc_pkg::SC_BEATS - 1));
  assign beat    = nals.valid && nals.ready;
  assign pop     = beat && (!head.is_sc || sc_last);
  assign full    = (count == CntW'(QUEUE_DEPTH));

  assign nals.valid         = (count != '0);
  assign nals.out_byte      = head.is_sc ? (sc_last ? 8'h01 : 8'h00) : head.data;
  assign nals.is_start_code = head.is_sc;
  assign nals.nal_end       = !head.is_sc && head.nal_end;
  assign nals.run_last      = !head.is_sc || sc_last;

  always_ff @(posedge clk) begin
    if (push.valid) begin
      queue[wr_ptr] <= push.grp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      count   <= '0;
      sc_beat <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= (wr_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (push.valid && !pop) begin
        count <= count + CntW'(1);
      end else if (pop && !push.valid) begin
        count <= count - CntW'(1);
      end
      if (beat && head.is_sc) begin
        sc_beat <= sc_last ? 2'd0 : sc_beat + 2'd1;
      end
    end
  end

endmodule

// ===== sim/tb_avcc_to_annexb_nal_converter.sv =====
`timescale 1ns / 1ps
// self-checking bench for the avcc to annex-b converter: a scoreboard tracks length headers
// and predicts start-code and payload beats. depends on avcc_pkg, avcc_in_if, avcc_out_if
// and avcc_to_annexb_nal_converter

module tb_avcc_to_annexb_nal_converter;

  localparam int TARGET_BYTES = 460;
  localparam int HOLD_CYCLES  = 250;

  typedef struct packed {
    logic [7:0] data;
    logic       sc;
    logic       nal_end;
    logic       run_last;
  } annexb_beat_t;

  class annexb_scoreboard;
    avcc_pkg::mode_t mode    = avcc_pkg::MODE_DISCARD;
    logic [1:0]  hdr_cnt     = '0;
    logic [31:0] len_acc     = '0;
    logic [31:0] nal_left    = '0;
    logic [31:0] sample_left = '0;
    annexb_beat_t pending_beats[$];
    int errors    = 0;
    int sc_runs   = 0;
    int nal_units = 0;
    int beats_out = 0;

    function void open_header();
      mode    = avcc_pkg::MODE_HEADER;
      hdr_cnt = '0;
      len_acc = '0;
    endfunction

    function void push_beat(logic [7:0] d, logic sc, logic ne, logic rl);
      annexb_beat_t b;
      b.data     = d;
      b.sc       = sc;
      b.nal_end  = ne;
      b.run_last = rl;
      pending_beats.push_back(b);
    endfunction

    // returns 1 when the byte lies inside a sample
    function bit take_byte(logic [7:0] b, logic first, logic [31:0] len);
      if (first) begin
        sample_left = len;
        nal_left    = '0;
        open_header();
      end
      if (sample_left == 0) begin
        mode = avcc_pkg::MODE_DISCARD;
        return 0;
      end
      sample_left--;
      case (mode)
        avcc_pkg::MODE_HEADER: begin
          len_acc = {len_acc[23:0], b};
          if (hdr_cnt == avcc_pkg::LENGTH_FIELD_BYTES - 1) begin
            hdr_cnt = '0;
            if (len_acc == 0 || len_acc > sample_left) begin
              mode = avcc_pkg::MODE_DISCARD;
            end else begin
              nal_left = len_acc;
              mode     = avcc_pkg::MODE_PAYLOAD;
              sc_runs++;
              for (int i = 0; i < avcc_pkg::SC_BEATS; i++)
                push_beat((i == avcc_pkg::SC_BEATS - 1) ? 8'h01 : 8'h00, 1'b1, 1'b0,
                          i == avcc_pkg::SC_BEATS - 1);
            end
          end else begin
            hdr_cnt = hdr_cnt + 2'd1;
          end
        end
        avcc_pkg::MODE_PAYLOAD: begin
          if (nal_left != 0)
            nal_left--;
          push_beat(b, 1'b0, nal_left == 0, 1'b1);
          if (nal_left == 0) begin
            nal_units++;
            open_header();
          end
        end
        default: mode = avcc_pkg::MODE_DISCARD;
      endcase
      return 1;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 50)
        $display("mismatch at %0t ns: %s", $time, msg);
    endtask

    task check_beat(annexb_beat_t got);
      annexb_beat_t want;
      beats_out++;
      if (pending_beats.size() == 0) begin
        report($sformatf("beat %02h with nothing expected", got.data));
        return;
      end
      want = pending_beats.pop_front();
      if (got.data !== want.data)
        report($sformatf("out_byte %02h, expected %02h", got.data, want.data));
      if (got.sc !== want.sc)
        report($sformatf("is_start_code %b, expected %b", got.sc, want.sc));
      if (got.nal_end !== want.nal_end)
        report($sformatf("nal_end %b, expected %b", got.nal_end, want.nal_end));
      if (got.run_last !== want.run_last)
        report($sformatf("run_last %b, expected %b", got.run_last, want.run_last));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  avcc_in_if  sample_bus ();
  avcc_out_if annexb_bus ();

  avcc_to_annexb_nal_converter dut (
    .clk     (clk),
    .rst     (rst),
    .samples (sample_bus),
    .nals    (annexb_bus)
  );

  annexb_scoreboard sb = new();
  int   sample_bytes_seen = 0;
  int   samples_sent      = 0;
  bit   hold_req          = 1'b0;
  logic [7:0] sample_bytes[$];

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (sample_bus.valid && sample_bus.ready) begin
        if (sb.take_byte(sample_bus.in_byte, sample_bus.sample_first, sample_bus.sample_len))
          sample_bytes_seen++;
      end
      if (annexb_bus.valid && annexb_bus.ready)
        sb.check_beat({annexb_bus.out_byte, annexb_bus.is_start_code, annexb_bus.nal_end,
                       annexb_bus.run_last});
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    else if (r < 90)
      return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // entered and left at a falling edge
  task automatic send_beat(input logic [7:0] b, input logic first, input logic [31:0] len,
                           input bit gapless);
    int gap;
    gap = gapless ? 0 : pick_gap();
    if (gap > 0) begin
      sample_bus.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample_bus.in_byte      = b;
    sample_bus.sample_first = first;
    sample_bus.sample_len   = len;
    sample_bus.valid        = 1'b1;
    do
      @(posedge clk);
    while (!sample_bus.ready);
    @(negedge clk);
  endtask

  task automatic send_sample(input logic [31:0] len, input int keep);
    bit gapless;
    gapless = ($urandom_range(0, 4) == 0);
    samples_sent++;
    for (int i = 0; i < keep; i++)
      send_beat(sample_bytes[i], i == 0, (i == 0) ? len : 32'($urandom), gapless);
  endtask

  task automatic push_len(input logic [31:0] v);
    for (int i = 3; i >= 0; i--)
      sample_bytes.push_back(v[8*i +: 8]);
  endtask

  task automatic push_nal(input int plen);
    push_len(plen);
    repeat (plen) sample_bytes.push_back(pick_byte());
  endtask

  // well-formed samples mostly, then bad lengths, short samples, empty samples and strays
  task automatic random_sample();
    int kind, k;
    logic [31:0] len, v;
    sample_bytes.delete();
    kind = $urandom_range(0, 99);
    if (kind < 60) begin
      repeat ($urandom_range(1, 3))
        push_nal(($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8));
      if ($urandom_range(0, 4) == 0)
        repeat ($urandom_range(1, 3)) sample_bytes.push_back(pick_byte());
      len = sample_bytes.size();
      if ($urandom_range(0, 6) == 0) begin
        v = $urandom;
        len = (v < len) ? v + len : v;
      end
      k = ($urandom_range(0, 7) == 0) ? $urandom_range(1, sample_bytes.size())
                                      : sample_bytes.size();
      send_sample(len, k);
    end else if (kind < 75) begin
      if ($urandom_range(0, 2) == 0)
        push_nal($urandom_range(1, 6));
      k = $urandom_range(0, 6);
      if ($urandom_range(0, 2) == 0) begin
        v = '0;
      end else if ($urandom_range(0, 1) == 0) begin
        v = $urandom;
        if (v <= k)
          v = k + 1;
      end else begin
        v = k + $urandom_range(1, 3);
      end
      push_len(v);
      repeat (k) sample_bytes.push_back(pick_byte());
      send_sample(sample_bytes.size(), sample_bytes.size());
    end else if (kind < 83) begin
      repeat ($urandom_range(1, 3)) sample_bytes.push_back(pick_byte());
      send_sample(sample_bytes.size(), sample_bytes.size());
    end else if (kind < 88) begin
      sample_bytes.push_back(pick_byte());
      send_sample(32'd0, 1);
    end else if (kind < 95) begin
      repeat ($urandom_range(1, 3))
        send_beat(pick_byte(), 1'b0, 32'($urandom), 1'b0);
    end else begin
      repeat ($urandom_range(1, 10)) sample_bytes.push_back(pick_byte());
      send_sample($urandom_range(0, 12), sample_bytes.size());
    end
  endtask

  // receiver: bursts of ready with short and long stalls, plus the requested hold-offs
  initial begin
    int run, idle;
    annexb_bus.ready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        annexb_bus.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      annexb_bus.ready = 1'b1;
      repeat (run) @(negedge clk);
      idle = pick_gap();
      if (idle > 0) begin
        annexb_bus.ready = 1'b0;
        repeat (idle) @(negedge clk);
      end
    end
  end

  initial begin
    bit second_hold;
    second_hold             = 1'b0;
    sample_bus.valid        = 1'b0;
    sample_bus.in_byte      = '0;
    sample_bus.sample_first = 1'b0;
    sample_bus.sample_len   = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // stray byte out of reset, empty sample, partial header
    send_beat(8'hA5, 1'b0, 32'hFFFF_FFFF, 1'b0);
    send_beat(8'h00, 1'b1, 32'd0, 1'b0);
    sample_bytes = '{8'h12, 8'h34, 8'h56};
    send_sample(32'd3, 3);
    // one-byte nal filling the sample
    sample_bytes = '{8'h00, 8'h00, 8'h00, 8'h01, 8'hFF};
    send_sample(32'd5, 5);
    // zero length
    sample_bytes = '{8'h00, 8'h00, 8'h00, 8'h00};
    send_sample(32'd4, 4);
    // length one beyond what is left, then a byte past the sample
    sample_bytes = '{8'h00, 8'h00, 8'h00, 8'h03, 8'h11, 8'h22};
    send_sample(32'd6, 6);
    send_beat(8'hFF, 1'b0, 32'd0, 1'b0);
    // all-ones length in an all-ones sample
    sample_bytes = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_sample(32'hFFFF_FFFF, 4);

    hold_req = 1'b1;
    while (sample_bytes_seen < TARGET_BYTES) begin
      if (!second_hold && sample_bytes_seen > TARGET_BYTES / 2) begin
        hold_req    = 1'b1;
        second_hold = 1'b1;
      end
      random_sample();
    end
    sample_bus.valid = 1'b0;

    while (sb.pending_beats.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d samples, %0d sample bytes, %0d start codes, %0d complete nal units",
             samples_sent, sample_bytes_seen, sb.sc_runs, sb.nal_units);
    $display("checked %0d output beats, %0d mismatches", sb.beats_out, sb.errors);
    if (sb.errors == 0)
      $display("[avcc_to_annexb_nal_converter] OK");
    else
      $display("[avcc_to_annexb_nal_converter] ERROR");
    $finish;
  end

  initial begin
    #(6_000_000);
    $display("timeout with %0d beats outstanding", sb.pending_beats.size());
    $display("[avcc_to_annexb_nal_converter] ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/avcc_pkg.sv
sv/avcc_in_if.sv
sv/avcc_out_if.sv
sv/avcc_emit.sv
sv/avcc_to_annexb_nal_converter.sv
sim/tb_avcc_to_annexb_nal_converter.sv
